@@ rtl/core/ipa_pkg.sv @@
// ipa_pkg: shared types and codes for the index pool allocator
// payload structs, function and status codes, sequencer states
// no dependencies
package ipa_pkg;

	localparam logic [10:0] ENTRY_COUNT_RST = 11'd1024;

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_NEXT   = 2'd2,
		FN_REINIT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BAD      = 3'd2,
		ST_ALREADY  = 3'd3,
		ST_NOT_USED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC,
		S_W2,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] slot_index;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  result_slot;
		logic        is_last;
		logic [9:0]  first_used;
		logic        any_used;
		logic [10:0] used_count;
	} out_t;

endpackage

@@ rtl/core/ipa_ram.sv @@
// ipa_ram: single write port, single read port synchronous memory
// read data registered; no dependencies
module ipa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/ipa_seq.sv @@
// ipa_seq: allocator sequencer, list registers and read-modify-write control
// drives the link memory and the prev memory; uses ipa_pkg
module ipa_seq #(
	parameter int POOL_DEPTH = 1024,
	parameter int IW = $clog2(POOL_DEPTH),
	parameter int CW = $clog2(POOL_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ipa_pkg::in_t  in_data,
	input  logic [10:0]   entry_count,
	output logic          res_valid,
	input  logic          res_ready,
	output ipa_pkg::out_t res_data,
	output logic          a_we,
	output logic [IW-1:0] a_waddr,
	output logic [IW:0]   a_wdata,
	output logic [IW-1:0] a_raddr,
	input  logic [IW:0]   a_rdata,
	output logic          b_we,
	output logic [IW-1:0] b_waddr,
	output logic [IW-1:0] b_wdata,
	output logic [IW-1:0] b_raddr,
	input  logic [IW-1:0] b_rdata
);
	import ipa_pkg::*;

	localparam int KW = (CW > 11) ? CW : 11;
	localparam logic [CW-1:0] ACT_RST =
		(int'(ENTRY_COUNT_RST) > POOL_DEPTH) ? CW'(POOL_DEPTH) : CW'(ENTRY_COUNT_RST);

	seq_state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [IW-1:0] idx_q;
	logic          idx_bad_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] sw_q;
	logic          sweep_res_q;
	logic [IW-1:0] free_head_q;
	logic          free_empty_q;
	logic [IW-1:0] use_head_q;
	logic [IW-1:0] use_tail_q;
	logic          use_empty_q;
	logic [CW-1:0] live_q;
	logic [2:0]    status_q;
	logic [IW-1:0] rslot_q;
	logic          last_q;
	logic [IW-1:0] w2_addr_q;
	logic [IW-1:0] w2_next_q;

	logic          accept;
	logic [IW-1:0] in_idx;
	logic          in_bad;
	logic [CW-1:0] clip_n;
	logic [CW-1:0] sw_inc;
	logic          sw_last;
	logic          a_used;
	logic [IW-1:0] a_next;
	logic          p_eq, n_eq;
	logic          alloc_ok, free_ok, next_ok;
	logic          need_w2;

	assign accept = in_valid && in_ready;
	assign in_idx = IW'(in_data.slot_index);
	assign in_bad = KW'(in_data.slot_index) >= KW'(active_q);
	assign sw_inc = sw_q + CW'(1);
	assign sw_last = (sw_inc == active_q);

	always_comb begin
		if (entry_count == 11'd0) begin
			clip_n = CW'(1);
		end else if (KW'(entry_count) > KW'(POOL_DEPTH)) begin
			clip_n = CW'(POOL_DEPTH);
		end else begin
			clip_n = CW'(entry_count);
		end
	end

	// decode of the read data returned for the transaction in flight
	always_comb begin
		a_used   = a_rdata[IW];
		a_next   = a_rdata[IW-1:0];
		p_eq     = (b_rdata == idx_q);
		n_eq     = (a_next == idx_q);
		alloc_ok = (op_q == FN_ALLOC) && !free_empty_q;
		free_ok  = (op_q == FN_FREE) && !use_empty_q && !idx_bad_q && a_used;
		next_ok  = (op_q == FN_NEXT) && !idx_bad_q && a_used;
		need_w2  = (alloc_ok && !use_empty_q) || (free_ok && !p_eq);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: if (sw_last) state_d = sweep_res_q ? S_DONE : S_IDLE;
			S_IDLE: begin
				if (accept) state_d = (in_data.func == FN_REINIT) ? S_SWEEP : S_EXEC;
			end
			S_EXEC:  state_d = need_w2 ? S_W2 : S_DONE;
			S_W2:    state_d = S_DONE;
			S_DONE:  if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
		a_raddr   = (in_data.func == FN_ALLOC) ? free_head_q : in_idx;
		b_raddr   = in_idx;
		a_we      = 1'b0;
		a_waddr   = sw_q[IW-1:0];
		a_wdata   = {1'b0, sw_last ? sw_q[IW-1:0] : sw_inc[IW-1:0]};
		b_we      = 1'b0;
		b_waddr   = free_head_q;
		b_wdata   = use_tail_q;
		case (state_q)
			S_SWEEP: a_we = 1'b1;
			S_EXEC: begin
				if (alloc_ok) begin
					a_we    = 1'b1;
					a_waddr = free_head_q;
					a_wdata = {1'b1, free_head_q};
					b_we    = 1'b1;
					b_waddr = free_head_q;
					b_wdata = use_empty_q ? free_head_q : use_tail_q;
				end else if (free_ok) begin
					a_we    = 1'b1;
					a_waddr = idx_q;
					a_wdata = {1'b0, free_empty_q ? idx_q : free_head_q};
					b_we    = !n_eq;
					b_waddr = a_next;
					b_wdata = p_eq ? a_next : b_rdata;
				end
			end
			S_W2: begin
				a_we    = 1'b1;
				a_waddr = w2_addr_q;
				a_wdata = {1'b1, w2_next_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		res_data.status      = status_q;
		res_data.result_slot = 10'(rslot_q);
		res_data.is_last     = last_q;
		res_data.first_used  = use_empty_q ? 10'd0 : 10'(use_head_q);
		res_data.any_used    = !use_empty_q;
		res_data.used_count  = 11'(live_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			active_q     <= ACT_RST;
			sw_q         <= '0;
			sweep_res_q  <= 1'b0;
			free_head_q  <= '0;
			free_empty_q <= 1'b0;
			use_head_q   <= '0;
			use_tail_q   <= '0;
			use_empty_q  <= 1'b1;
			live_q       <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_SWEEP: sw_q <= sw_inc;
				S_IDLE: begin
					if (accept && in_data.func == FN_REINIT) begin
						active_q     <= clip_n;
						sw_q         <= '0;
						sweep_res_q  <= 1'b1;
						free_head_q  <= '0;
						free_empty_q <= 1'b0;
						use_head_q   <= '0;
						use_tail_q   <= '0;
						use_empty_q  <= 1'b1;
						live_q       <= '0;
					end
				end
				S_EXEC: begin
					if (alloc_ok) begin
						if (a_next == free_head_q) begin
							free_empty_q <= 1'b1;
						end else begin
							free_head_q <= a_next;
						end
						if (use_empty_q) begin
							use_head_q  <= free_head_q;
							use_empty_q <= 1'b0;
						end
						use_tail_q <= free_head_q;
						live_q     <= live_q + CW'(1);
					end else if (free_ok) begin
						if (p_eq && n_eq) begin
							use_empty_q <= 1'b1;
							use_head_q  <= '0;
							use_tail_q  <= '0;
						end else if (p_eq) begin
							use_head_q <= a_next;
						end else if (n_eq) begin
							use_tail_q <= b_rdata;
						end
						free_head_q  <= idx_q;
						free_empty_q <= 1'b0;
						live_q       <= live_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= in_data.func;
				idx_q     <= in_idx;
				idx_bad_q <= in_bad;
				status_q  <= ST_OK;
				rslot_q   <= '0;
				last_q    <= 1'b0;
			end
			S_EXEC: begin
				last_q <= 1'b0;
				if (alloc_ok) begin
					status_q  <= ST_OK;
					rslot_q   <= free_head_q;
					w2_addr_q <= use_tail_q;
					w2_next_q <= free_head_q;
				end else if (free_ok) begin
					status_q  <= ST_OK;
					rslot_q   <= idx_q;
					w2_addr_q <= b_rdata;
					w2_next_q <= n_eq ? b_rdata : a_next;
				end else if (next_ok) begin
					status_q <= ST_OK;
					rslot_q  <= a_next;
					last_q   <= n_eq;
				end else begin
					rslot_q <= '0;
					if (op_q == FN_ALLOC) begin
						status_q <= ST_FULL;
					end else if (op_q == FN_FREE) begin
						status_q <= (use_empty_q || idx_bad_q) ? ST_BAD : ST_ALREADY;
					end else begin
						status_q <= idx_bad_q ? ST_BAD : ST_NOT_USED;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/index_pool_allocator_core.sv @@
// index_pool_allocator_core: top level of the index pool allocator
// instantiates ipa_seq and two ipa_ram memories, link and prev; uses ipa_pkg
//
// A pool of POOL_DEPTH slots handed out by index. Free slots form a singly
// linked free list, slots in use a doubly linked list, kept in two memories
// with registered read data: a link memory holding {in-use mark, next} and
// a prev memory. Each transaction reads both memories once; next and
// rejected transactions then go from EXEC to DONE, while alloc and free
// write back in EXEC and, where a second link changes, in W2. Reinit and
// reset run a clearing pass over each managed slot in turn (entry_count
// clipped to 1..POOL_DEPTH, 1024 clipped alike after reset) during which no
// transaction is accepted; the reinit result is given when the pass ends.
// entry_count takes effect only at reinit and reset.
// A finished result sits in an output register, so the next transaction can
// be accepted while it waits.
module index_pool_allocator_core #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ipa_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ipa_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [10:0]   cfg_wdata
);
	import ipa_pkg::*;

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);

	logic [10:0] entry_count_q;
	logic        res_valid, res_ready;
	out_t        res_data;
	logic        out_valid_q;
	out_t        out_data_q;

	// link memory ports: {in-use mark, next}
	logic          a_we;
	logic [IW-1:0] a_waddr, a_raddr;
	logic [IW:0]   a_wdata, a_rdata;
	// prev memory ports
	logic          b_we;
	logic [IW-1:0] b_waddr, b_raddr, b_wdata, b_rdata;

	// configuration register, latched by the sequencer at reinit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	ipa_seq #(
		.POOL_DEPTH(POOL_DEPTH),
		.IW(IW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.entry_count(entry_count_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.a_we(a_we),
		.a_waddr(a_waddr),
		.a_wdata(a_wdata),
		.a_raddr(a_raddr),
		.a_rdata(a_rdata),
		.b_we(b_we),
		.b_waddr(b_waddr),
		.b_wdata(b_wdata),
		.b_raddr(b_raddr),
		.b_rdata(b_rdata)
	);

	ipa_ram #(
		.W(IW + 1),
		.DEPTH(POOL_DEPTH),
		.AW(IW)
	) u_link_mem (
		.clk(clk),
		.we(a_we),
		.waddr(a_waddr),
		.wdata(a_wdata),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	// prev links need no clearing: only read for slots in use
	ipa_ram #(
		.W(IW),
		.DEPTH(POOL_DEPTH),
		.AW(IW)
	) u_prev_mem (
		.clk(clk),
		.we(b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	// output register parts the sequencer from the consumer
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
